// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the depth back-projection block
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DPB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DPB_NEVER(label, clk, rst, cond, msg) \
  `DPB_ASSERT(label, clk, rst, !(cond), msg)
`else
`define DPB_ASSERT(label, clk, rst, prop, msg)
`define DPB_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/dpb_pkg.sv =====
// shared constants and types of the depth back-projection block
// no dependencies
package dpb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int RAW_W          = 16;
  localparam int SCALE_W        = 24;
  localparam int DIST_W         = 24;
  localparam int SCALE_SHIFT    = 8;
  localparam int COEF_W         = 21;
  localparam int COEF_FRAC      = 18;
  localparam int MROW_W         = 3 * COEF_W;
  localparam int PT_W           = 26;
  localparam int PT_MAX         = 2 ** (PT_W - 1) - 1;
  localparam int PT_MIN         = -(2 ** (PT_W - 1));
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = MROW_W;
  localparam int QUEUE_DEPTH    = 4;
  localparam int BACK_LAT       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_UNIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT  = 3'd5;

  localparam logic [MROW_W-1:0]  RST_INV_ROW_X  = 63'd262144;
  localparam logic [MROW_W-1:0]  RST_INV_ROW_Y  = 63'd549755813888;
  localparam logic [MROW_W-1:0]  RST_INV_ROW_Z  = 63'd1152921504606846976;
  localparam logic [SCALE_W-1:0] RST_DEPTH_UNIT = 24'd16777;
  localparam logic [DIST_W-1:0]  RST_NEAR_LIMIT = 24'd655;
  localparam logic [DIST_W-1:0]  RST_FAR_LIMIT  = 24'd655360;

  typedef struct packed {
    logic full;
    logic empty;
    logic almost_full;
  } q_status_t;

endpackage

// ===== hw/rtl/dpb_front.sv =====
// front end: takes pixels, scales depth to metres, drops out-of-range samples
// depends on dpb_pkg
module dpb_front import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [RAW_W-1:0]        depth_raw,
  input  logic [COORD_BITS-1:0]   pixel_row,
  input  logic [COORD_BITS-1:0]   pixel_col,
  input  logic [SCALE_W-1:0]      depth_unit_scale,
  input  logic [DIST_W-1:0]       near_limit,
  input  logic [DIST_W-1:0]       far_limit,
  output logic                    push,
  output logic [DIST_W+2*COORD_BITS-1:0] push_data
);

  localparam int PROD_W = RAW_W + SCALE_W;
  localparam int SHR_W  = PROD_W - SCALE_SHIFT;

  logic                  f1_valid;
  logic                  f1_nz;
  logic [PROD_W-1:0]     f1_prod;
  logic [COORD_BITS-1:0] f1_row;
  logic [COORD_BITS-1:0] f1_col;
  logic [SHR_W-1:0]      depth_shr;
  logic [DIST_W-1:0]     depth_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
    f1_nz   <= |depth_raw;
    f1_prod <= PROD_W'(depth_raw) * PROD_W'(depth_unit_scale);
    f1_row  <= pixel_row;
    f1_col  <= pixel_col;
  end

  // saturate scaled depth to the distance width
  assign depth_shr = f1_prod[PROD_W-1:SCALE_SHIFT];
  assign depth_m = (|depth_shr[SHR_W-1:DIST_W]) ? {DIST_W{1'b1}} : depth_shr[DIST_W-1:0];

  assign push      = f1_valid && f1_nz && (depth_m > near_limit) && (depth_m < far_limit);
  assign push_data = {depth_m, f1_row, f1_col};

endmodule

// ===== hw/rtl/dpb_queue.sv =====
// short flip-flop queue between front and back ends
// depends on dpb_pkg
module dpb_queue import dpb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_status_t        status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data           = mem[rd_ptr];
  assign status.full        = (count == CNT_W'(DEPTH));
  assign status.empty       = (count == '0);
  assign status.almost_full = (count >= CNT_W'(DEPTH - 1));

endmodule

// ===== hw/rtl/dpb_back.sv =====
// back end: inverse camera matrix times (col*d, row*d, d), floor and saturate
// depends on dpb_pkg
module dpb_back import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [DIST_W+2*COORD_BITS-1:0] in_data,
  input  logic [MROW_W-1:0]              inv_row_x,
  input  logic [MROW_W-1:0]              inv_row_y,
  input  logic [MROW_W-1:0]              inv_row_z,
  output logic                           done,
  output logic signed [PT_W-1:0]         point_x,
  output logic signed [PT_W-1:0]         point_y,
  output logic signed [PT_W-1:0]         point_z
);

  localparam int CRD_W  = COORD_BITS + 1;
  localparam int DS_W   = DIST_W + 1;
  localparam int CP_W   = COEF_W + CRD_W;
  localparam int TERM_W = CP_W + DS_W;
  localparam int DT_W   = COEF_W + DS_W;
  localparam int SUM_W  = TERM_W + 2;
  localparam logic signed [SUM_W-1:0] QMAX = SUM_W'(PT_MAX);
  localparam logic signed [SUM_W-1:0] QMIN = SUM_W'(PT_MIN);

  logic [MROW_W-1:0]         mrow [3];
  logic signed [COEF_W-1:0]  cf   [3][3];
  logic signed [CRD_W-1:0]   col_s;
  logic signed [CRD_W-1:0]   row_s;

  logic                      b1_valid;
  logic signed [DS_W-1:0]    b1_dist;
  logic signed [CP_W-1:0]    b1_pc [3];
  logic signed [CP_W-1:0]    b1_pr [3];

  logic                      b2_valid;
  logic signed [TERM_W-1:0]  b2_tc [3];
  logic signed [TERM_W-1:0]  b2_tr [3];
  logic signed [DT_W-1:0]    b2_td [3];

  logic                      b3_valid;
  logic signed [SUM_W-1:0]   b3_sum [3];

  logic signed [SUM_W-1:0]   q    [3];
  logic signed [PT_W-1:0]    qsat [3];

  assign mrow[0] = inv_row_x;
  assign mrow[1] = inv_row_y;
  assign mrow[2] = inv_row_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int s = 0; s < 3; s++) begin
        cf[r][s] = $signed(mrow[r][s*COEF_W +: COEF_W]);
      end
    end
  end

  assign col_s = $signed({1'b0, in_data[COORD_BITS-1:0]});
  assign row_s = $signed({1'b0, in_data[2*COORD_BITS-1:COORD_BITS]});

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      b1_valid <= in_valid;
      b2_valid <= b1_valid;
      b3_valid <= b2_valid;
      done     <= b3_valid;
    end
    b1_dist <= $signed({1'b0, in_data[DIST_W+2*COORD_BITS-1:2*COORD_BITS]});
    for (int r = 0; r < 3; r++) begin
      b1_pc[r]  <= CP_W'(cf[r][0]) * CP_W'(col_s);
      b1_pr[r]  <= CP_W'(cf[r][1]) * CP_W'(row_s);
      b2_tc[r]  <= TERM_W'(b1_pc[r]) * TERM_W'(b1_dist);
      b2_tr[r]  <= TERM_W'(b1_pr[r]) * TERM_W'(b1_dist);
      b2_td[r]  <= DT_W'(cf[r][2]) * DT_W'(b1_dist);
      b3_sum[r] <= SUM_W'(b2_tc[r]) + SUM_W'(b2_tr[r]) + SUM_W'(b2_td[r]);
    end
    point_x <= qsat[0];
    point_y <= qsat[1];
    point_z <= qsat[2];
  end

  // arithmetic shift floors toward minus infinity
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      q[r] = b3_sum[r] >>> COEF_FRAC;
      if (q[r] > QMAX) begin
        qsat[r] = PT_W'(PT_MAX);
      end else if (q[r] < QMIN) begin
        qsat[r] = PT_W'(PT_MIN);
      end else begin
        qsat[r] = q[r][PT_W-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/depth_pixel_backproject.sv =====
// top level of the depth back-projection block: config registers, front, queue, back
// depends on dpb_pkg, dpb_front, dpb_queue, dpb_back, assert_macros.svh
//
// One depth pixel can be started every clock cycle while busy is low. A pixel
// whose raw depth is nonzero and whose scaled distance lies strictly between
// near_limit and far_limit comes out as a point after the front stage, the
// queue and the back end, with done high for exactly one cycle; other pixels
// produce nothing. The back end is a multiplier pipeline (coefficient times
// coordinate, times distance, row sum, floor and saturate) behind one front
// stage and the queue. Results cannot be held off, so points must be taken
// in the cycle done is high. busy is high during reset and whenever the queue
// between front and back holds QUEUE_DEPTH-1 or more entries; registers are
// written with cfg_we and should only change while no pixel is in flight.
`include "assert_macros.svh"
module depth_pixel_backproject import dpb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [RAW_W-1:0]      depth_raw,
  input  logic [COORD_BITS-1:0] pixel_row,
  input  logic [COORD_BITS-1:0] pixel_col,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic signed [PT_W-1:0] point_x,
  output logic signed [PT_W-1:0] point_y,
  output logic signed [PT_W-1:0] point_z
);

  localparam int QW = DIST_W + 2 * COORD_BITS;

  logic [MROW_W-1:0]  inv_row_x;
  logic [MROW_W-1:0]  inv_row_y;
  logic [MROW_W-1:0]  inv_row_z;
  logic [SCALE_W-1:0] depth_unit_scale;
  logic [DIST_W-1:0]  near_limit;
  logic [DIST_W-1:0]  far_limit;

  logic               accept;
  logic               q_push;
  logic [QW-1:0]      q_push_data;
  logic               q_pop;
  logic [QW-1:0]      q_pop_data;
  q_status_t          q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_row_x        <= RST_INV_ROW_X;
      inv_row_y        <= RST_INV_ROW_Y;
      inv_row_z        <= RST_INV_ROW_Z;
      depth_unit_scale <= RST_DEPTH_UNIT;
      near_limit       <= RST_NEAR_LIMIT;
      far_limit        <= RST_FAR_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INV_ROW_X:  inv_row_x        <= cfg_data;
        REG_INV_ROW_Y:  inv_row_y        <= cfg_data;
        REG_INV_ROW_Z:  inv_row_z        <= cfg_data;
        REG_DEPTH_UNIT: depth_unit_scale <= cfg_data[SCALE_W-1:0];
        REG_NEAR_LIMIT: near_limit       <= cfg_data[DIST_W-1:0];
        REG_FAR_LIMIT:  far_limit        <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = rst || q_stat.almost_full;
  assign accept = start && !busy;
  assign q_pop  = !q_stat.empty;

  dpb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .depth_raw        (depth_raw),
    .pixel_row        (pixel_row),
    .pixel_col        (pixel_col),
    .depth_unit_scale (depth_unit_scale),
    .near_limit       (near_limit),
    .far_limit        (far_limit),
    .push             (q_push),
    .push_data        (q_push_data)
  );

  dpb_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_stat)
  );

  dpb_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_pop),
    .in_data   (q_pop_data),
    .inv_row_x (inv_row_x),
    .inv_row_y (inv_row_y),
    .inv_row_z (inv_row_z),
    .done      (done),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z)
  );

  `DPB_NEVER(a_queue_overflow, clk, rst, q_push && q_stat.full, "queue push while full")
  `DPB_ASSERT(a_done_from_pop, clk, rst, done |-> $past(q_pop, BACK_LAT), "done without pop")
  `DPB_ASSERT(a_zero_dropped, clk, rst, (accept && !(|depth_raw)) |-> ##6 !done, "zero depth point")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench of depth_pixel_backproject: pixel transfers, register settings,
// an in-bench back-projection predictor and a point checker; depends on dpb_pkg and the rtl
module tb_top;
  import dpb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PIXELS = 1880;
  localparam int TAIL_PIXELS   = 200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [RAW_W-1:0] depth_raw = '0;
  logic [COORD_BITS_DEF-1:0] pixel_row = '0;
  logic [COORD_BITS_DEF-1:0] pixel_col = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;

  // register shadow
  logic [MROW_W-1:0] camera_row [3] = '{RST_INV_ROW_X, RST_INV_ROW_Y, RST_INV_ROW_Z};
  logic [SCALE_W-1:0] unit_scale = RST_DEPTH_UNIT;
  logic [DIST_W-1:0] near_dist = RST_NEAR_LIMIT;
  logic [DIST_W-1:0] far_dist = RST_FAR_LIMIT;

  point_t pending_points [$];
  point_t want;
  int cycle_count = 0;
  int err_count = 0;
  int pixels_sent = 0;
  int points_expected = 0;
  int points_checked = 0;
  int reg_writes = 0;

  depth_pixel_backproject dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .depth_raw(depth_raw),
    .pixel_row(pixel_row),
    .pixel_col(pixel_col),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z)
  );

  always #10 clk = ~clk;

  function automatic logic signed [PT_W-1:0] project_axis(input logic [MROW_W-1:0] coefs,
                                                          input longint cx, ry, dd);
    logic signed [COEF_W-1:0] c_col, c_row, c_dist;
    longint acc, q;
    c_col = coefs[COEF_W-1:0];
    c_row = coefs[2*COEF_W-1:COEF_W];
    c_dist = coefs[3*COEF_W-1:2*COEF_W];
    acc = longint'(c_col) * cx + longint'(c_row) * ry + longint'(c_dist) * dd;
    q = acc >>> COEF_FRAC;
    if (q > longint'(PT_MAX)) q = longint'(PT_MAX);
    else if (q < longint'(PT_MIN)) q = longint'(PT_MIN);
    return q[PT_W-1:0];
  endfunction

  function automatic bit backproject_pixel(input logic [RAW_W-1:0] raw,
                                           input logic [COORD_BITS_DEF-1:0] row, col,
                                           output point_t pt);
    logic [RAW_W+SCALE_W-1:0] prod;
    logic [DIST_W-1:0] depth_m;
    longint cx, ry, dd;
    prod = (RAW_W+SCALE_W)'(raw) * (RAW_W+SCALE_W)'(unit_scale);
    if (|prod[RAW_W+SCALE_W-1:SCALE_SHIFT+DIST_W]) depth_m = '1;
    else depth_m = prod[SCALE_SHIFT+DIST_W-1:SCALE_SHIFT];
    if (raw == '0 || !(depth_m < far_dist) || !(depth_m > near_dist)) return 0;
    dd = longint'(depth_m);
    cx = longint'(col) * dd;
    ry = longint'(row) * dd;
    pt.x = project_axis(camera_row[0], cx, ry, dd);
    pt.y = project_axis(camera_row[1], cx, ry, dd);
    pt.z = project_axis(camera_row[2], cx, ry, dd);
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [PT_W-1:0] got, exp_val);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, exp_val, cycle_count);
    err_count++;
  endtask

  // point checker
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycle_count,
               pending_points.size());
      $display("Some tests failed");
      $finish;
    end else if (!rst && done) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point_x", point_x, '0);
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) report_mismatch("point_x", point_x, want.x);
        if (point_y !== want.y) report_mismatch("point_y", point_y, want.y);
        if (point_z !== want.z) report_mismatch("point_z", point_z, want.z);
        points_checked++;
      end
    end
  end

  task automatic send_pixel(input logic [RAW_W-1:0] raw,
                            input logic [COORD_BITS_DEF-1:0] row, col);
    point_t pt;
    start <= 1'b1;
    depth_raw <= raw;
    pixel_row <= row;
    pixel_col <= col;
    do @(posedge clk); while (busy);
    pixels_sent++;
    if (backproject_pixel(raw, row, col, pt)) begin
      pending_points = {pending_points, pt};
      points_expected++;
    end
  endtask

  task automatic idle_burst(input int cycles);
    start <= 1'b0;
    depth_raw <= RAW_W'($urandom);
    pixel_row <= COORD_BITS_DEF'($urandom);
    pixel_col <= COORD_BITS_DEF'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // no start while the last points drain out
  task automatic settle();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_INV_ROW_X:  camera_row[0] = data;
      REG_INV_ROW_Y:  camera_row[1] = data;
      REG_INV_ROW_Z:  camera_row[2] = data;
      REG_DEPTH_UNIT: unit_scale = data[SCALE_W-1:0];
      REG_NEAR_LIMIT: near_dist = data[DIST_W-1:0];
      REG_FAR_LIMIT:  far_dist = data[DIST_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_wide();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_row(input logic [COEF_W-1:0] c_col, c_row,
                                                     c_dist);
    return {c_dist, c_row, c_col};
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    logic [COEF_W-1:0] mag;
    case ($urandom_range(0, 3))
      0: return COEF_W'($urandom);
      1: mag = COEF_W'($urandom_range(0, 127));
      2: mag = COEF_W'($urandom_range(0, 1 << COEF_FRAC));
      default: mag = '0;
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // 24-bit registers carry random junk above their width
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [DIST_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = rand_wide();
    data[DIST_W-1:0] = value;
    return data;
  endfunction

  task automatic program_scene();
    write_reg(REG_INV_ROW_X, pack_row(rand_coef(), rand_coef(), rand_coef()));
    write_reg(REG_INV_ROW_Y, pack_row(rand_coef(), rand_coef(), rand_coef()));
    write_reg(REG_INV_ROW_Z, pack_row(rand_coef(), rand_coef(), rand_coef()));
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_DEPTH_UNIT, with_junk(DIST_W'($urandom_range(1000, 40000))));
      write_reg(REG_NEAR_LIMIT, with_junk(DIST_W'($urandom_range(0, 2000))));
      write_reg(REG_FAR_LIMIT, with_junk(DIST_W'($urandom_range(600000, 24'hFFFFFF))));
    end else begin
      write_reg(REG_DEPTH_UNIT, rand_wide());
      write_reg(REG_NEAR_LIMIT, rand_wide());
      write_reg(REG_FAR_LIMIT, rand_wide());
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand_wide());
  endtask

  task automatic send_random_pixel();
    logic [RAW_W-1:0] raw;
    logic [COORD_BITS_DEF-1:0] row, col;
    case ($urandom_range(0, 15))
      0:       raw = '0;
      1, 2:    raw = RAW_W'($urandom_range(1, 64));
      default: raw = RAW_W'($urandom);
    endcase
    row = ($urandom_range(0, 3) == 0) ? COORD_BITS_DEF'($urandom_range(0, 15))
                                      : COORD_BITS_DEF'($urandom);
    col = ($urandom_range(0, 3) == 0) ? COORD_BITS_DEF'($urandom_range(0, 15))
                                      : COORD_BITS_DEF'($urandom);
    send_pixel(raw, row, col);
  endtask

  // reset settings: identity matrix, 1 mm units, window 0.01 m to 10 m
  task automatic test_default_window();
    send_pixel(16'd0, 12'd100, 12'd200);
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'd10, 12'd5, 12'd5);
    send_pixel(16'd11, 12'd0, 12'd0);
    send_pixel(16'd11, 12'hFFF, 12'hFFF);
    send_pixel(16'd9999, 12'd1, 12'd1);
    send_pixel(16'd10000, 12'hFFF, 12'd0);
    send_pixel(16'd10001, 12'd0, 12'hFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    send_pixel(16'd2000, 12'd2048, 12'd1024);
    settle();
  endtask

  // extreme coefficients, saturation both ways, depth overflow, closed windows
  task automatic test_extreme_registers();
    write_reg(REG_INV_ROW_X, pack_row(21'h100000, 21'h100000, 21'h100000));
    write_reg(REG_INV_ROW_Y, pack_row(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF));
    write_reg(REG_INV_ROW_Z, pack_row(21'd0, 21'd0, 21'h040000));
    write_reg(REG_DEPTH_UNIT, {{(CFG_DATA_W-SCALE_W){1'b1}}, 24'hFFFFFF});
    write_reg(REG_NEAR_LIMIT, {{(CFG_DATA_W-DIST_W){1'b1}}, 24'd0});
    write_reg(REG_FAR_LIMIT, with_junk(24'hFFFFFF));
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    send_pixel(16'd256, 12'd0, 12'd0);
    send_pixel(16'd255, 12'hFFF, 12'hFFF);
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'd1, 12'hFFF, 12'd0);
    send_pixel(16'd1, 12'd0, 12'hFFF);
    settle();
    write_reg(REG_DEPTH_UNIT, with_junk(24'd1));
    send_pixel(16'd255, 12'd7, 12'd7);
    send_pixel(16'd256, 12'd7, 12'd7);
    settle();
    write_reg(REG_NEAR_LIMIT, with_junk(24'hFFFFFF));
    write_reg(REG_DEPTH_UNIT, with_junk(24'd40000));
    send_pixel(16'd40000, 12'd1, 12'd1);
    settle();
    write_reg(REG_NEAR_LIMIT, with_junk(24'd0));
    write_reg(REG_FAR_LIMIT, with_junk(24'd0));
    send_pixel(16'd40000, 12'd1, 12'd1);
    settle();
  endtask

  task automatic test_random_scenes();
    int budget, burst_len;
    bit idle_on;
    budget = RANDOM_PIXELS;
    while (budget > 0) begin
      program_scene();
      idle_on = (budget > TAIL_PIXELS) && ($urandom_range(0, 3) != 0);
      burst_len = $urandom_range(60, 140);
      if (burst_len > budget) burst_len = budget;
      repeat (burst_len) begin
        send_random_pixel();
        if (idle_on && $urandom_range(0, 5) == 0) idle_burst($urandom_range(1, 12));
      end
      budget -= burst_len;
      settle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_window();
    test_extreme_registers();
    test_random_scenes();
    settle();
    $display("%0d pixel transfers over %0d register writes", pixels_sent, reg_writes);
    $display("%0d of %0d expected points checked, %0d pixels rejected", points_checked,
             points_expected, pixels_sent - points_expected);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
